>>> rtl/mpbf_pkg.sv
// ----------------------------------------------------------------------------
// mpbf_pkg
// Shared types, constants and the 2x2 reduction function of the mipmap
// pyramid box filter.
// ----------------------------------------------------------------------------
package mpbf_pkg;

  localparam int unsigned MaxSizeLog2 = 11;
  localparam int unsigned LevelCount  = MaxSizeLog2;
  localparam int unsigned PairDepth   = 1 << (MaxSizeLog2 - 1);
  localparam int unsigned PairAw      = MaxSizeLog2 - 1;
  localparam int unsigned PosW        = MaxSizeLog2;
  localparam int unsigned CoordW      = 10;
  localparam int unsigned LevelW      = 4;
  localparam int unsigned TexelW      = 32;
  localparam int unsigned OutDataW    = 56;

  localparam logic [1:0] RegWidthLog2   = 2'd0;
  localparam logic [1:0] RegHeightLog2  = 2'd1;
  localparam logic [1:0] RegChannelCnt  = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [LevelW-1:0]   level;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic [TexelW-1:0]   texel;
    logic                run_last;
    logic                image_last;
  } res_t;

  function automatic logic [TexelW-1:0] combine4(
    input logic [TexelW-1:0] a,
    input logic [TexelW-1:0] b,
    input logic [TexelW-1:0] c,
    input logic [TexelW-1:0] d,
    input logic [2:0]        nch
  );
    logic [TexelW-1:0] r;
    logic [9:0]        sum;
    logic [7:0]        m;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      sum = {2'b00, a[8*i +: 8]} + {2'b00, b[8*i +: 8]}
          + {2'b00, c[8*i +: 8]} + {2'b00, d[8*i +: 8]};
      m = a[8*i +: 8];
      if (b[8*i +: 8] > m) m = b[8*i +: 8];
      if (c[8*i +: 8] > m) m = c[8*i +: 8];
      if (d[8*i +: 8] > m) m = d[8*i +: 8];
      if (i < int'(nch)) begin
        if (nch == 3'd4 && i == 3) r[8*i +: 8] = m;
        else r[8*i +: 8] = sum[9:2];
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/mpbf_ram.sv
// ----------------------------------------------------------------------------
// mpbf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mpbf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/mpbf_cell.sv
// ----------------------------------------------------------------------------
// mpbf_cell
// One pyramid level: position tracking, row pair store, held texel and the
// 2x2 reduction; hands its reduced texel to the next level.
// ----------------------------------------------------------------------------
module mpbf_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         clear_i,
  input  logic [3:0]                   idx_i,
  input  logic [3:0]                   wl_i,
  input  logic [3:0]                   hl_i,
  input  logic [3:0]                   nlev_i,
  input  logic [2:0]                   nch_i,
  input  logic                         in_valid_i,
  input  logic [mpbf_pkg::TexelW-1:0]  in_texel_i,
  input  logic                         next_emit_i,
  output logic                         will_emit_o,
  output logic                         cont_o,
  output logic [mpbf_pkg::TexelW-1:0]  cont_texel_o,
  output logic                         busy_o,
  output mpbf_pkg::res_t               res_o
);
  import mpbf_pkg::*;

  logic [3:0]        wlog, hlog;
  logic [PosW-1:0]   x_q, x_d, y_q, y_d, xc, yc;
  logic [TexelW-1:0] held_q;
  logic              b_valid_q;
  logic [PosW-1:0]   b_x_q, b_y_q;
  logic [TexelW-1:0] b_t_q;
  logic              fwd_hit_q;
  logic [63:0]       fwd_data_q;
  logic [63:0]       rdata, pair;
  logic              act, emit, we;
  logic [63:0]       wdata;
  logic [TexelW-1:0] a, b, r;

  assign wlog = (wl_i > idx_i) ? wl_i - idx_i : 4'd0;
  assign hlog = (hl_i > idx_i) ? hl_i - idx_i : 4'd0;

  assign xc = ((x_q >> wlog) != '0) ? '0 : x_q;
  assign yc = ((y_q >> hlog) != '0) ? '0 : y_q;

  assign will_emit_o = (wlog == 4'd0 || xc[0]) && (hlog == 4'd0 || yc[0]);

  // one extra bit so that the last column of the widest level still wraps
  always_comb begin
    if ((({1'b0, xc} + {{PosW{1'b0}}, 1'b1}) >> wlog) != '0) begin
      x_d = '0;
      y_d = ((({1'b0, yc} + {{PosW{1'b0}}, 1'b1}) >> hlog) != '0) ? '0 : yc + PosW'(1);
    end else begin
      x_d = xc + PosW'(1);
      y_d = yc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      held_q    <= '0;
      b_valid_q <= 1'b0;
    end else if (clear_i) begin
      x_q    <= '0;
      y_q    <= '0;
      held_q <= '0;
    end else if (en_i) begin
      b_valid_q <= in_valid_i;
      if (in_valid_i) begin
        x_q <= x_d;
        y_q <= y_d;
      end
      if (b_valid_q && wlog != 4'd0 && !b_x_q[0]) held_q <= b_t_q;
    end
  end

  // row pairs: high half is the odd column, low half the even one
  assign act   = b_valid_q && en_i;
  assign we    = act && hlog != 4'd0 && !b_y_q[0] && (wlog == 4'd0 || b_x_q[0]);
  assign wdata = (wlog == 4'd0) ? {b_t_q, b_t_q} : {b_t_q, held_q};

  always_ff @(posedge clk_i) begin
    if (en_i && in_valid_i) begin
      b_x_q      <= xc;
      b_y_q      <= yc;
      b_t_q      <= in_texel_i;
      fwd_hit_q  <= we && (b_x_q[PosW-1:1] == xc[PosW-1:1]);
      fwd_data_q <= wdata;
    end
  end

  mpbf_ram #(
    .Width (64),
    .Depth (PairDepth)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (b_x_q[PosW-1:1]),
    .wdata_i (wdata),
    .re_i    (en_i && in_valid_i),
    .raddr_i (xc[PosW-1:1]),
    .rdata_o (rdata)
  );

  assign pair = fwd_hit_q ? fwd_data_q : rdata;

  always_comb begin
    if (wlog == 4'd0) begin
      a = b_t_q;
      b = b_t_q;
    end else begin
      a = held_q;
      b = b_t_q;
    end
    if (hlog == 4'd0) r = combine4(a, b, a, b, nch_i);
    else              r = combine4(pair[31:0], a, pair[63:32], b, nch_i);
  end

  assign emit   = (wlog == 4'd0 || b_x_q[0]) && (hlog == 4'd0 || b_y_q[0]);
  assign busy_o = b_valid_q;
  assign cont_o = b_valid_q && emit && (({1'b0, idx_i} + 5'd1) < {1'b0, nlev_i});
  assign cont_texel_o = r;

  always_comb begin
    res_o            = '0;
    res_o.valid      = b_valid_q && emit;
    res_o.level      = idx_i + 4'd1;
    res_o.x          = b_x_q[PosW-1:1];
    res_o.y          = b_y_q[PosW-1:1];
    res_o.texel      = r;
    res_o.run_last   = !(cont_o && next_emit_i);
    res_o.image_last = (idx_i + 4'd1) == nlev_i;
  end

endmodule

>>> rtl/mipmap_pyramid_box_filter.sv
// ----------------------------------------------------------------------------
// mipmap_pyramid_box_filter
// Builds a full 2x2 box-filtered mipmap pyramid from a raster texel stream.
// ----------------------------------------------------------------------------
// level-0 texels enter one per transfer in raster order; every reduced texel
// leaves as one output transfer, lowest level first, tlast on the last result
// of an input and tuser on the top texel of the pyramid. a texel walks a chain
// of level cells, one cell after another, and each of its results is held in
// the output register before it is offered. a new texel waits while an earlier
// one is still climbing the chain: texels that hand nothing on past the first
// cell follow back to back, and one that does holds the input until it has
// left the chain. a stalled output freezes the whole chain and the input with
// it. writing any register restarts the image at position zero.
module mipmap_pyramid_box_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // in_c0, in_c1, in_c2, in_c3
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // out_level, out_x, out_y, out_c0..out_c3
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser    // image_last
);
  import mpbf_pkg::*;

  logic [3:0] width_log2_q, height_log2_q;
  logic [2:0] channel_count_q;
  logic [3:0] wl, hl, nlev;
  logic [2:0] nch;
  logic       en, busy;
  logic [TexelW-1:0] in_texel;

  logic [LevelCount-1:0] in_valid, will_emit, next_emit, cont, cell_busy;
  logic [TexelW-1:0]     in_tex   [LevelCount];
  logic [TexelW-1:0]     cont_tex [LevelCount];
  res_t                  res      [LevelCount];
  res_t                  sel, out_q;
  logic                  out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q    <= 4'd8;
      height_log2_q   <= 4'd8;
      channel_count_q <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidthLog2:  width_log2_q    <= cfg_wdata_i;
        RegHeightLog2: height_log2_q   <= cfg_wdata_i;
        RegChannelCnt: channel_count_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign wl   = (width_log2_q  > 4'(MaxSizeLog2)) ? 4'(MaxSizeLog2) : width_log2_q;
  assign hl   = (height_log2_q > 4'(MaxSizeLog2)) ? 4'(MaxSizeLog2) : height_log2_q;
  assign nlev = (wl > hl) ? wl : hl;
  assign nch  = (channel_count_q == 3'd0) ? 3'd1 :
                (channel_count_q > 3'd4) ? 3'd4 : channel_count_q;

  always_comb begin
    in_texel = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < int'(nch)) in_texel[8*i +: 8] = s_axis_tdata[8*i +: 8];
    end
  end

  assign en = !out_valid_q || m_axis_tready;

  // no new texel while an earlier one is still climbing the chain
  always_comb begin
    busy = cont[0];
    for (int l = 1; l < LevelCount; l++) busy = busy | cont[l] | cell_busy[l];
  end
  assign s_axis_tready = en && !busy;

  assign in_valid[0] = s_axis_tvalid && s_axis_tready && nlev != 4'd0;
  assign in_tex[0]   = in_texel;

  for (genvar l = 0; l < LevelCount; l++) begin : g_cell
    if (l + 1 < LevelCount) begin : g_link
      assign in_valid[l+1]  = cont[l];
      assign in_tex[l+1]    = cont_tex[l];
      assign next_emit[l]   = will_emit[l+1];
    end else begin : g_end
      assign next_emit[l] = 1'b0;
    end

    mpbf_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (en),
      .clear_i      (cfg_we_i),
      .idx_i        (4'(l)),
      .wl_i         (wl),
      .hl_i         (hl),
      .nlev_i       (nlev),
      .nch_i        (nch),
      .in_valid_i   (in_valid[l]),
      .in_texel_i   (in_tex[l]),
      .next_emit_i  (next_emit[l]),
      .will_emit_o  (will_emit[l]),
      .cont_o       (cont[l]),
      .cont_texel_o (cont_tex[l]),
      .busy_o       (cell_busy[l]),
      .res_o        (res[l])
    );
  end

  // at most one cell holds a result in any cycle
  always_comb begin
    sel = '0;
    for (int l = 0; l < LevelCount; l++) begin
      if (res[l].valid) sel = sel | res[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sel.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= sel;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.texel, out_q.y, out_q.x, out_q.level};
  assign m_axis_tlast  = out_q.run_last;
  assign m_axis_tuser  = out_q.image_last;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the mipmap pyramid box filter: level-0 texels are
// streamed in, and every reduced texel that comes out is checked against an
// in-bench model of the 2x2 pyramid build.
// ----------------------------------------------------------------------------
module testbench;
  import mpbf_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int unsigned RowDepth = 4096;
  localparam int unsigned DrainWait = 40;
  localparam longint unsigned CycleLimit = 400000;

  typedef enum logic { ROW_CFG, ROW_TEXEL } row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [3:0]  value;
    logic [31:0] data;
    bit          has_exp;
    logic [31:0] exp_texel;
  } stim_row_t;

  typedef struct {
    logic [3:0]  level;
    logic [9:0]  x;
    logic [9:0]  y;
    logic [31:0] texel;
    logic        run_last;
    logic        image_last;
  } mip_texel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [3:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  mipmap_pyramid_box_filter u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [31:0] pyr_row_store [RowDepth];
  logic [31:0] pyr_held [12];
  int unsigned pyr_col [12];
  int unsigned pyr_row [12];
  logic [3:0]  pyr_wlog2 = 4'd8;
  logic [3:0]  pyr_hlog2 = 4'd8;
  logic [2:0]  pyr_chans = 3'd4;

  mip_texel_t  pending_texels[$];
  int unsigned errors = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold = 0;
  longint unsigned cycles = 0;

  function automatic logic [31:0] reduce2x2(logic [31:0] a, logic [31:0] b,
                                            logic [31:0] c, logic [31:0] d,
                                            int unsigned nch);
    logic [31:0] r;
    logic [9:0]  sum;
    logic [7:0]  m;
    r = '0;
    for (int i = 0; i < int'(nch); i++) begin
      sum = 10'(a[8*i +: 8]) + 10'(b[8*i +: 8]) + 10'(c[8*i +: 8]) + 10'(d[8*i +: 8]);
      m = a[8*i +: 8];
      if (b[8*i +: 8] > m) m = b[8*i +: 8];
      if (c[8*i +: 8] > m) m = c[8*i +: 8];
      if (d[8*i +: 8] > m) m = d[8*i +: 8];
      // alpha keeps the strongest coverage
      r[8*i +: 8] = (nch == 4 && i == 3) ? m : sum[9:2];
    end
    return r;
  endfunction

  function automatic void restart_pyramid();
    for (int l = 0; l < 12; l++) begin
      pyr_held[l] = '0;
      pyr_col[l] = 0;
      pyr_row[l] = 0;
    end
  endfunction

  function automatic void predict_mip_texels(logic [31:0] d);
    int unsigned wl, hl, nlev, nch, lvl, base, wlog, hlog, w, h, x, y, x1, x1b, n0;
    logic [31:0] t, a, b, r;
    mip_texel_t  e;
    wl = (pyr_wlog2 > 11) ? 11 : pyr_wlog2;
    hl = (pyr_hlog2 > 11) ? 11 : pyr_hlog2;
    nlev = (wl > hl) ? wl : hl;
    nch = (pyr_chans == 0) ? 1 : ((pyr_chans > 4) ? 4 : pyr_chans);
    t = '0;
    for (int i = 0; i < int'(nch); i++) t[8*i +: 8] = d[8*i +: 8];
    base = 0;
    lvl = 0;
    n0 = pending_texels.size();
    while (lvl < nlev) begin
      wlog = (wl > lvl) ? wl - lvl : 0;
      hlog = (hl > lvl) ? hl - lvl : 0;
      w = 1 << wlog;
      h = 1 << hlog;
      x = (pyr_col[lvl] >= w) ? 0 : pyr_col[lvl];
      y = (pyr_row[lvl] >= h) ? 0 : pyr_row[lvl];
      if (x + 1 >= w) begin
        pyr_col[lvl] = 0;
        pyr_row[lvl] = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        pyr_col[lvl] = x + 1;
        pyr_row[lvl] = y;
      end
      if (hlog > 0 && y[0] == 1'b0) pyr_row_store[(base + x) % RowDepth] = t;
      if (wlog == 0) begin
        a = t;
        b = t;
        x1 = 0;
        x1b = 0;
      end else if (x[0] == 1'b0) begin
        pyr_held[lvl] = t;
        break;
      end else begin
        a = pyr_held[lvl];
        b = t;
        x1 = x - 1;
        x1b = x;
      end
      if (hlog == 0) begin
        r = reduce2x2(a, b, a, b, nch);
      end else if (y[0] == 1'b0) begin
        break;
      end else begin
        r = reduce2x2(pyr_row_store[(base + x1) % RowDepth], a,
                      pyr_row_store[(base + x1b) % RowDepth], b, nch);
      end
      e.level = 4'(lvl + 1);
      e.x = 10'(x >> 1);
      e.y = 10'(y >> 1);
      e.texel = r;
      e.run_last = 1'b0;
      e.image_last = (lvl + 1 == nlev);
      pending_texels.push_back(e);
      base += w;
      t = r;
      lvl++;
    end
    if (pending_texels.size() > n0) pending_texels[$].run_last = 1'b1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // register write, only once the block has drained
  task automatic write_reg(logic [1:0] idx, logic [3:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_texels.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegWidthLog2:  pyr_wlog2 = value;
      RegHeightLog2: pyr_hlog2 = value;
      RegChannelCnt: pyr_chans = value[2:0];
      default: ;
    endcase
    restart_pyramid();
  endtask

  task automatic send_texel(logic [31:0] d, bit has_exp, logic [31:0] exp_texel);
    int unsigned n0;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    n0 = pending_texels.size();
    predict_mip_texels(d);
    if (has_exp && pending_texels.size() == n0 + 1)
      pending_texels[$] = '{4'd1, 10'd0, 10'd0, exp_texel, 1'b1, 1'b1};
  endtask

  task automatic run_image(logic [3:0] wl, logic [3:0] hl, logic [2:0] ch, int unsigned n);
    write_reg(RegWidthLog2, wl);
    write_reg(RegHeightLog2, hl);
    write_reg(RegChannelCnt, {1'b0, ch});
    for (int i = 0; i < int'(n); i++) send_texel($urandom, 1'b0, '0);
  endtask

  // receiver side
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    mip_texel_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_texels.size() == 0) begin
        report("unexpected transfer", m_axis_tdata[31:0], '0);
      end else begin
        e = pending_texels.pop_front();
        if (m_axis_tdata[3:0] != e.level) report("level", m_axis_tdata[3:0], e.level);
        if (m_axis_tdata[13:4] != e.x) report("x", m_axis_tdata[13:4], e.x);
        if (m_axis_tdata[23:14] != e.y) report("y", m_axis_tdata[23:14], e.y);
        if (m_axis_tdata[55:24] != e.texel) report("texel", m_axis_tdata[55:24], e.texel);
        if (m_axis_tlast != e.run_last) report("tlast", m_axis_tlast, e.run_last);
        if (m_axis_tuser != e.image_last) report("tuser", m_axis_tuser, e.image_last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  stim_row_t directed[] = '{
    '{ROW_TEXEL, RegUnused, 4'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_CFG, RegWidthLog2, 4'd1, '0, 1'b0, '0},
    '{ROW_CFG, RegHeightLog2, 4'd0, '0, 1'b0, '0},
    '{ROW_CFG, RegChannelCnt, 4'd4, '0, 1'b0, '0},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'h281E_140A, 1'b0, '0},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'h3C32_281E, 1'b1, 32'h3C28_1E14},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'h0000_0000, 1'b0, '0},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'h0000_0000, 1'b1, 32'h0000_0000},
    // zero channels acts as one
    '{ROW_CFG, RegChannelCnt, 4'd0, '0, 1'b0, '0},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'hFFFF_FF03, 1'b0, '0},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'hFFFF_FF04, 1'b1, 32'h0000_0003},
    // ignored index still restarts the image
    '{ROW_TEXEL, RegUnused, 4'd0, 32'h1234_5678, 1'b0, '0},
    '{ROW_CFG, RegUnused, 4'd5, '0, 1'b0, '0},
    '{ROW_CFG, RegChannelCnt, 4'd7, '0, 1'b0, '0},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'h8000_0001, 1'b0, '0},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'h7FFF_FFFE, 1'b0, '0},
    // oversized sizes clamp to the maximum
    '{ROW_CFG, RegWidthLog2, 4'd15, '0, 1'b0, '0},
    '{ROW_CFG, RegHeightLog2, 4'd13, '0, 1'b0, '0},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'hA5A5_5A5A, 1'b0, '0},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'h5A5A_A5A5, 1'b0, '0},
    // single texel image gives nothing
    '{ROW_CFG, RegWidthLog2, 4'd0, '0, 1'b0, '0},
    '{ROW_CFG, RegHeightLog2, 4'd0, '0, 1'b0, '0},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'hDEAD_BEEF, 1'b0, '0},
    '{ROW_TEXEL, RegUnused, 4'd0, 32'hCAFE_F00D, 1'b0, '0}
  };

  initial begin
    int unsigned sent;
    int unsigned wl, hl, n;
    restart_pyramid();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) write_reg(directed[i].idx, directed[i].value);
      else send_texel(directed[i].data, directed[i].has_exp, directed[i].exp_texel);
    end

    sent = 0;
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 7 : ((mode == 1) ? 67 : 0);
      rx_idle_pct = (mode == 0) ? 67 : ((mode == 1) ? 7 : 0);
      if (mode == 0) begin
        // long receiver stall so the block backs up into its input
        run_image(4'd2, 4'd2, 3'd4, 0);
        rx_hold = 300;
        for (int i = 0; i < 32; i++) send_texel($urandom, 1'b0, '0);
        sent += 32;
      end
      while (sent < 35 * (mode + 1)) begin
        wl = $urandom_range(0, 2);
        hl = $urandom_range(0, 2);
        n = (1 << (wl + hl)) * $urandom_range(1, 2) + $urandom_range(0, 3);
        run_image(4'(wl), 4'(hl), 3'($urandom_range(0, 7)), n);
        if ($urandom_range(3) == 0) write_reg(RegUnused, 4'($urandom));
        sent += n;
      end
    end
    // extremes: start of the widest strip, tallest column, largest square
    run_image(4'd11, 4'd0, 3'd4, 24);
    run_image(4'd0, 4'd11, 3'd3, 12);
    run_image(4'd11, 4'd11, 3'd2, 8);
    s_axis_tvalid <= 1'b0;

    while (pending_texels.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> mipmap_pyramid_box_filter.f
rtl/mpbf_pkg.sv
rtl/mpbf_ram.sv
rtl/mpbf_cell.sv
rtl/mipmap_pyramid_box_filter.sv
tb/testbench.sv
